FILE: hw/rtl/lhm_pkg.sv
package lhm_pkg;

   // default widths for the top level parameters
   localparam int RTT_BITS_DEFAULT   = 24;
   localparam int COUNT_BITS_DEFAULT = 16;

   // configuration port geometry
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOWN_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EWMA_ALPHA_Q8   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPIKE_FACTOR_Q4 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPIKE_FLOOR_US  = 2'd3;

   // register reset values
   localparam logic [7:0]  DOWN_THRESHOLD_RESET  = 8'd3;
   localparam logic [8:0]  EWMA_ALPHA_Q8_RESET   = 9'd32;
   localparam logic [7:0]  SPIKE_FACTOR_Q4_RESET = 8'd32;
   localparam logic [23:0] SPIKE_FLOOR_US_RESET  = 24'd50000;

   // alpha of 1.0 in q1.8
   localparam logic [8:0] ALPHA_ONE = 9'd256;

   typedef struct packed {
      logic [7:0]  down_threshold;
      logic [8:0]  ewma_alpha_q8;
      logic [7:0]  spike_factor_q4;
      logic [23:0] spike_floor_us;
   } cfg_type;

   typedef struct packed {
      logic recovered;
      logic went_down;
      logic latency_rose;
      logic latency_cleared;
      logic link_down;
      logic latency_high;
   } flags_type;

endpackage

FILE: hw/rtl/link_health_monitor_core.sv
// link health monitor core
//
// input channel (req_*): one probe outcome per transfer, a success flag and
// a round-trip time in microseconds. result channel (rsp_*): one result per
// probe with event flags, the outage and latency states, failure run
// counters and the rtt baseline and smoothed value.
// configuration (csr_*): plain register writes, taken in the cycle the
// write enable is high; write only while no probe is in flight.
//
// a probe waits in the input register, then its result is loaded into the
// result register, where it is valid and can transfer. throughput: one probe
// per cycle while the receiver takes results; the whole state update is
// combinational logic between those two registers, its longest path the ewma
// multiply and the baseline times spike factor product followed by the compares.
// reset: counters and flags clear, the baseline goes to all ones, the ewma
// to zero and unseeded, registers take their default values.
// when the receiver stalls, the result register holds its item and one
// more probe waits in the input register; then req_ready drops.
module link_health_monitor_core #(
   parameter int RTT_BITS   = lhm_pkg::RTT_BITS_DEFAULT,
   parameter int COUNT_BITS = lhm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_probe_ok,
   input  logic [RTT_BITS-1:0]                req_rtt_us,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_recovered,
   output logic                               rsp_went_down,
   output logic                               rsp_latency_rose,
   output logic                               rsp_latency_cleared,
   output logic                               rsp_link_down,
   output logic                               rsp_latency_high,
   output logic [COUNT_BITS-1:0]              rsp_run_length,
   output logic [COUNT_BITS-1:0]              rsp_longest_run,
   output logic [COUNT_BITS-1:0]              rsp_outage_total,
   output logic [RTT_BITS-1:0]                rsp_baseline_us,
   output logic [RTT_BITS-1:0]                rsp_smoothed_us,
   input  logic                               csr_write_enable,
   input  logic [lhm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lhm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   lhm_pkg::cfg_type      cfg;
   lhm_pkg::flags_type    res_flags;
   lhm_pkg::flags_type    out_flags;
   logic                  item_valid;
   logic                  item_probe_ok;
   logic [RTT_BITS-1:0]   item_rtt_us;
   logic                  advance;
   logic [COUNT_BITS-1:0] res_run_length;
   logic [COUNT_BITS-1:0] res_longest_run;
   logic [COUNT_BITS-1:0] res_outage_total;
   logic [RTT_BITS-1:0]   res_baseline_us;
   logic [RTT_BITS-1:0]   res_smoothed_us;

   // held probe moves into the result register when that is free
   assign advance = item_valid && (!rsp_valid || rsp_ready);

   lhm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   lhm_in_stage #(
      .RTT_BITS (RTT_BITS)
   ) u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_probe_ok  (req_probe_ok),
      .req_rtt_us    (req_rtt_us),
      .advance       (advance),
      .item_valid    (item_valid),
      .item_probe_ok (item_probe_ok),
      .item_rtt_us   (item_rtt_us)
   );

   lhm_update #(
      .RTT_BITS   (RTT_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_update (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .probe_ok         (item_probe_ok),
      .rtt_us           (item_rtt_us),
      .cfg              (cfg),
      .res_flags        (res_flags),
      .res_run_length   (res_run_length),
      .res_longest_run  (res_longest_run),
      .res_outage_total (res_outage_total),
      .res_baseline_us  (res_baseline_us),
      .res_smoothed_us  (res_smoothed_us)
   );

   lhm_out_stage #(
      .RTT_BITS   (RTT_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_out_stage (
      .clock            (clock),
      .reset            (reset),
      .load             (advance),
      .res_flags        (res_flags),
      .res_run_length   (res_run_length),
      .res_longest_run  (res_longest_run),
      .res_outage_total (res_outage_total),
      .res_baseline_us  (res_baseline_us),
      .res_smoothed_us  (res_smoothed_us),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_flags        (out_flags),
      .rsp_run_length   (rsp_run_length),
      .rsp_longest_run  (rsp_longest_run),
      .rsp_outage_total (rsp_outage_total),
      .rsp_baseline_us  (rsp_baseline_us),
      .rsp_smoothed_us  (rsp_smoothed_us)
   );

   assign rsp_recovered       = out_flags.recovered;
   assign rsp_went_down       = out_flags.went_down;
   assign rsp_latency_rose    = out_flags.latency_rose;
   assign rsp_latency_cleared = out_flags.latency_cleared;
   assign rsp_link_down       = out_flags.link_down;
   assign rsp_latency_high    = out_flags.latency_high;

   // a probe is either a success or a failure, never both events
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_recovered && rsp_went_down))
      else $error("recovered and went_down in one result");

   // outage events agree with the reported link state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_went_down || rsp_link_down) && (!rsp_recovered || !rsp_link_down))
      else $error("outage event disagrees with link_down");

   // latency events agree with the reported latency state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_latency_rose || rsp_latency_high)
                 && (!rsp_latency_cleared || !rsp_latency_high))
      else $error("latency event disagrees with latency_high");

   // the reported run never exceeds the longest run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_run_length <= rsp_longest_run)
      else $error("run_length above longest_run");

endmodule

FILE: hw/rtl/lhm_csr.sv
module lhm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [lhm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lhm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output lhm_pkg::cfg_type                     cfg
);

   lhm_pkg::cfg_type cfg_ff;
   lhm_pkg::cfg_type cfg_in;

   // decode one register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lhm_pkg::CSR_DOWN_THRESHOLD:  cfg_in.down_threshold  = csr_wdata[7:0];
            lhm_pkg::CSR_EWMA_ALPHA_Q8:   cfg_in.ewma_alpha_q8   = csr_wdata[8:0];
            lhm_pkg::CSR_SPIKE_FACTOR_Q4: cfg_in.spike_factor_q4 = csr_wdata[7:0];
            lhm_pkg::CSR_SPIKE_FLOOR_US:  cfg_in.spike_floor_us  = csr_wdata[23:0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.down_threshold  <= lhm_pkg::DOWN_THRESHOLD_RESET;
         cfg_ff.ewma_alpha_q8   <= lhm_pkg::EWMA_ALPHA_Q8_RESET;
         cfg_ff.spike_factor_q4 <= lhm_pkg::SPIKE_FACTOR_Q4_RESET;
         cfg_ff.spike_floor_us  <= lhm_pkg::SPIKE_FLOOR_US_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/lhm_in_stage.sv
module lhm_in_stage #(
   parameter int RTT_BITS = lhm_pkg::RTT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_probe_ok,
   input  logic [RTT_BITS-1:0] req_rtt_us,
   input  logic                advance,
   output logic                item_valid,
   output logic                item_probe_ok,
   output logic [RTT_BITS-1:0] item_rtt_us
);

   logic                valid_ff;
   logic                valid_in;
   logic                probe_ok_ff;
   logic [RTT_BITS-1:0] rtt_ff;
   logic                take;

   // room when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture on transfer
   always_ff @(posedge clock) begin
      if (take) begin
         probe_ok_ff <= req_probe_ok;
         rtt_ff      <= req_rtt_us;
      end
   end

   assign item_valid    = valid_ff;
   assign item_probe_ok = probe_ok_ff;
   assign item_rtt_us   = rtt_ff;

endmodule

FILE: hw/rtl/lhm_update.sv
module lhm_update #(
   parameter int RTT_BITS   = lhm_pkg::RTT_BITS_DEFAULT,
   parameter int COUNT_BITS = lhm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  probe_ok,
   input  logic [RTT_BITS-1:0]   rtt_us,
   input  lhm_pkg::cfg_type      cfg,
   output lhm_pkg::flags_type    res_flags,
   output logic [COUNT_BITS-1:0] res_run_length,
   output logic [COUNT_BITS-1:0] res_longest_run,
   output logic [COUNT_BITS-1:0] res_outage_total,
   output logic [RTT_BITS-1:0]   res_baseline_us,
   output logic [RTT_BITS-1:0]   res_smoothed_us
);

   localparam int PROD_W  = RTT_BITS + 9;
   localparam int WSUM_W  = RTT_BITS + 10;
   localparam int SPIKE_W = RTT_BITS + 8;
   localparam int SUM_W   = ((RTT_BITS > 24) ? RTT_BITS : 24) + 1;
   localparam int HALF_W  = RTT_BITS + 2;

   logic [COUNT_BITS-1:0] fail_run_ff,     fail_run_in;
   logic [COUNT_BITS-1:0] max_fail_run_ff, max_fail_run_in;
   logic [COUNT_BITS-1:0] outage_count_ff, outage_count_in;
   logic                  down_flag_ff,    down_flag_in;
   logic [RTT_BITS-1:0]   min_rtt_ff,      min_rtt_in;
   logic [RTT_BITS-1:0]   ewma_rtt_ff,     ewma_rtt_in;
   logic                  ewma_seeded_ff,  ewma_seeded_in;
   logic                  slow_flag_ff,    slow_flag_in;

   logic                  fail_sat;
   logic [COUNT_BITS-1:0] fail_inc;
   logic [COUNT_BITS-1:0] max_cand;
   logic                  threshold_hit;
   logic [COUNT_BITS-1:0] outage_inc;
   logic [RTT_BITS-1:0]   min_new;
   logic [8:0]            alpha_c;
   logic [8:0]            alpha_rest;
   logic [PROD_W-1:0]     prod_new;
   logic [PROD_W-1:0]     prod_old;
   logic [WSUM_W-1:0]     wsum;
   logic [RTT_BITS-1:0]   ewma_new;
   logic [SPIKE_W-1:0]    spike_lhs;
   logic [SPIKE_W-1:0]    spike_rhs;
   logic [SUM_W-1:0]      floor_rhs;
   logic [HALF_W-1:0]     ewma_x2;
   logic [HALF_W-1:0]     min_x3;
   logic                  over_spike;
   logic                  over_floor;
   logic                  rise;
   logic                  fall;

   // failure run and outage counters, saturating
   always_comb begin
      fail_sat      = &fail_run_ff;
      fail_inc      = fail_sat ? fail_run_ff : fail_run_ff + 1'b1;
      max_cand      = (fail_inc > max_fail_run_ff) ? fail_inc : max_fail_run_ff;
      threshold_hit = !fail_sat && (fail_inc == COUNT_BITS'(cfg.down_threshold));
      outage_inc    = (&outage_count_ff) ? outage_count_ff : outage_count_ff + 1'b1;
   end

   // baseline and ewma blend
   always_comb begin
      min_new    = (rtt_us < min_rtt_ff) ? rtt_us : min_rtt_ff;
      alpha_c    = (cfg.ewma_alpha_q8 > lhm_pkg::ALPHA_ONE) ? lhm_pkg::ALPHA_ONE
                                                            : cfg.ewma_alpha_q8;
      alpha_rest = lhm_pkg::ALPHA_ONE - alpha_c;
      prod_new   = PROD_W'(alpha_c) * PROD_W'(rtt_us);
      prod_old   = PROD_W'(alpha_rest) * PROD_W'(ewma_rtt_ff);
      wsum       = WSUM_W'(prod_new) + WSUM_W'(prod_old);
      ewma_new   = ewma_seeded_ff ? wsum[RTT_BITS+7:8] : rtt_us;
   end

   // high latency hysteresis
   always_comb begin
      spike_lhs  = SPIKE_W'({ewma_new, 4'b0000});
      spike_rhs  = SPIKE_W'(min_new) * SPIKE_W'(cfg.spike_factor_q4);
      floor_rhs  = SUM_W'(min_new) + SUM_W'(cfg.spike_floor_us);
      ewma_x2    = HALF_W'({ewma_new, 1'b0});
      min_x3     = HALF_W'(min_new) + HALF_W'({min_new, 1'b0});
      over_spike = spike_lhs > spike_rhs;
      over_floor = SUM_W'(ewma_new) > floor_rhs;
      rise       = probe_ok && !slow_flag_ff && over_spike && over_floor;
      fall       = probe_ok && slow_flag_ff && (ewma_x2 < min_x3);
   end

   // next state for this item
   always_comb begin
      fail_run_in     = fail_run_ff;
      max_fail_run_in = max_fail_run_ff;
      outage_count_in = outage_count_ff;
      down_flag_in    = down_flag_ff;
      min_rtt_in      = min_rtt_ff;
      ewma_rtt_in     = ewma_rtt_ff;
      ewma_seeded_in  = ewma_seeded_ff;
      slow_flag_in    = slow_flag_ff;
      if (probe_ok) begin
         fail_run_in    = '0;
         down_flag_in   = 1'b0;
         min_rtt_in     = min_new;
         ewma_rtt_in    = ewma_new;
         ewma_seeded_in = 1'b1;
         if (rise) begin
            slow_flag_in = 1'b1;
         end else if (fall) begin
            slow_flag_in = 1'b0;
         end
      end else begin
         fail_run_in     = fail_inc;
         max_fail_run_in = max_cand;
         if (threshold_hit) begin
            down_flag_in    = 1'b1;
            outage_count_in = outage_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_run_ff     <= '0;
         max_fail_run_ff <= '0;
         outage_count_ff <= '0;
         down_flag_ff    <= 1'b0;
         min_rtt_ff      <= '1;
         ewma_rtt_ff     <= '0;
         ewma_seeded_ff  <= 1'b0;
         slow_flag_ff    <= 1'b0;
      end else if (advance) begin
         fail_run_ff     <= fail_run_in;
         max_fail_run_ff <= max_fail_run_in;
         outage_count_ff <= outage_count_in;
         down_flag_ff    <= down_flag_in;
         min_rtt_ff      <= min_rtt_in;
         ewma_rtt_ff     <= ewma_rtt_in;
         ewma_seeded_ff  <= ewma_seeded_in;
         slow_flag_ff    <= slow_flag_in;
      end
   end

   // result fields for this item
   always_comb begin
      res_flags.recovered       = probe_ok && down_flag_ff;
      res_flags.went_down       = !probe_ok && threshold_hit;
      res_flags.latency_rose    = rise;
      res_flags.latency_cleared = fall;
      res_flags.link_down       = down_flag_in;
      res_flags.latency_high    = slow_flag_in;
      res_run_length            = probe_ok ? fail_run_ff : fail_inc;
      res_longest_run           = max_fail_run_in;
      res_outage_total          = outage_count_in;
      res_baseline_us           = min_rtt_in;
      res_smoothed_us           = ewma_rtt_in;
   end

endmodule

FILE: hw/rtl/lhm_out_stage.sv
module lhm_out_stage #(
   parameter int RTT_BITS   = lhm_pkg::RTT_BITS_DEFAULT,
   parameter int COUNT_BITS = lhm_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  lhm_pkg::flags_type    res_flags,
   input  logic [COUNT_BITS-1:0] res_run_length,
   input  logic [COUNT_BITS-1:0] res_longest_run,
   input  logic [COUNT_BITS-1:0] res_outage_total,
   input  logic [RTT_BITS-1:0]   res_baseline_us,
   input  logic [RTT_BITS-1:0]   res_smoothed_us,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output lhm_pkg::flags_type    rsp_flags,
   output logic [COUNT_BITS-1:0] rsp_run_length,
   output logic [COUNT_BITS-1:0] rsp_longest_run,
   output logic [COUNT_BITS-1:0] rsp_outage_total,
   output logic [RTT_BITS-1:0]   rsp_baseline_us,
   output logic [RTT_BITS-1:0]   rsp_smoothed_us
);

   logic                  valid_ff;
   logic                  valid_in;
   lhm_pkg::flags_type    flags_ff;
   logic [COUNT_BITS-1:0] run_ff;
   logic [COUNT_BITS-1:0] longest_ff;
   logic [COUNT_BITS-1:0] outage_ff;
   logic [RTT_BITS-1:0]   baseline_ff;
   logic [RTT_BITS-1:0]   smoothed_ff;

   // result valid: set on load, dropped after transfer
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff    <= res_flags;
         run_ff      <= res_run_length;
         longest_ff  <= res_longest_run;
         outage_ff   <= res_outage_total;
         baseline_ff <= res_baseline_us;
         smoothed_ff <= res_smoothed_us;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_flags        = flags_ff;
   assign rsp_run_length   = run_ff;
   assign rsp_longest_run  = longest_ff;
   assign rsp_outage_total = outage_ff;
   assign rsp_baseline_us  = baseline_ff;
   assign rsp_smoothed_us  = smoothed_ff;

endmodule
